// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the UTF-8 decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every rising edge outside of reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds at a rising edge outside of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/core/u8dec_pkg.sv =====
// Types, constants and lead byte decoding shared by the UTF-8 decoder.
`default_nettype none

package u8dec_pkg;

	localparam int ByteW = 8;
	localparam int CpW   = 31;
	localparam int LenW  = 3;
	localparam int StW   = 2;

	// Bits of payload carried by one continuation byte.
	localparam int ContBits = 6;

	localparam logic [ByteW-1:0] ContSel = 8'hC0;
	localparam logic [ByteW-1:0] ContTag = 8'h80;

	typedef enum logic [StW-1:0] {
		ST_OK       = 2'd0,
		ST_BAD_LEAD = 2'd1,
		ST_BAD_CONT = 2'd2
	} status_t;

	// One result beat as it leaves the sequencer.
	typedef struct packed {
		logic             valid;
		logic [CpW-1:0]   code_point;
		logic [LenW-1:0]  seq_length;
		status_t          status;
	} result_t;

	// Sequence length for a multi-byte lead, or zero for a rejected lead.
	function automatic logic [LenW-1:0] lead_length(input logic [ByteW-1:0] b,
			input logic short_mode);
		logic [LenW-1:0] n;
		n = '0;
		if ((b & 8'hE0) == 8'hC0) begin
			n = 3'd2;
		end else if ((b & 8'hF0) == 8'hE0) begin
			n = 3'd3;
		end else if ((b & 8'hF8) == 8'hF0) begin
			n = 3'd4;
		end else if ((b & 8'hFC) == 8'hF8) begin
			n = short_mode ? 3'd0 : 3'd5;
		end else if ((b & 8'hFE) == 8'hFC) begin
			n = short_mode ? 3'd0 : 3'd6;
		end
		return n;
	endfunction

	// Payload bits of a lead byte, selected by its sequence length.
	function automatic logic [ByteW-1:0] lead_payload(input logic [ByteW-1:0] b,
			input logic [LenW-1:0] n);
		logic [ByteW-1:0] keep;
		case (n)
			3'd2:    keep = 8'h1F;
			3'd3:    keep = 8'h0F;
			3'd4:    keep = 8'h07;
			3'd5:    keep = 8'h03;
			3'd6:    keep = 8'h01;
			default: keep = 8'h00;
		endcase
		return b & keep;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/utf8_stream_decoder.sv =====
// Top level of the byte-serial UTF-8 stream decoder.
//
//   channel  direction  handshake            beat
//   in       sink       in_valid / in_stall  in_byte
//   out      source     out_valid / out_stall code_point, seq_length, status
//   cfg      sink       cfg_valid / cfg_ready cfg_data (max_length_mode)
//
// A byte is held in the input register; a byte that ends a sequence or is
// rejected puts its result in the result register. One byte is accepted per cycle while in_stall is low.
// The decode step sits between the input register and the result register.
// Reset clears the valid flags, the sequence state and the length mode.
// A stalled result holds the input register, which then raises in_stall.
`default_nettype none

`include "assert_macros.svh"

module utf8_stream_decoder (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [u8dec_pkg::ByteW-1:0] in_byte,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [u8dec_pkg::CpW-1:0]        code_point,
	output logic [u8dec_pkg::LenW-1:0]       seq_length,
	output logic [u8dec_pkg::StW-1:0]        status,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic                        cfg_data
);
	import u8dec_pkg::*;

	logic              valid_s1;
	logic [ByteW-1:0]  byte_s1;
	logic              mode_q;
	logic              out_valid_q;
	logic [CpW-1:0]    cp_q;
	logic [LenW-1:0]   len_q;
	status_t           status_q;
	logic              blocked;
	logic              advance;
	result_t           res;

	// The byte in the input register moves on unless a result is stuck.
	assign blocked   = out_valid_q && out_stall;
	assign advance   = valid_s1 && !blocked;
	assign in_stall  = valid_s1 && blocked;
	assign cfg_ready = 1'b1;

	// Length mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
	end

	u8dec_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (advance),
		.byte_in    (byte_s1),
		.short_mode (mode_q),
		.res        (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			cp_q     <= res.code_point;
			len_q    <= res.seq_length;
			status_q <= res.status;
		end
	end

	assign out_valid  = out_valid_q;
	assign code_point = cp_q;
	assign seq_length = len_q;
	assign status     = status_q;

	// Error beats carry no code point and no length.
	`ASSERT_PROP(a_err_zero, clk, arst_n, (out_valid_q && status_q != ST_OK) |-> (cp_q == '0 && len_q == '0), "error beat with payload")
	// A one-byte result is always plain ASCII.
	`ASSERT_PROP(a_ascii, clk, arst_n, (out_valid_q && status_q == ST_OK && len_q == 3'd1) |-> (cp_q < 31'd128), "one-byte result out of ASCII range")
	// A new result never lands on a stuck one.
	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, res.valid && blocked, "result overwrote a stalled beat")

endmodule

`default_nettype wire

// ===== rtl/core/u8dec_seq.sv =====
// Sequence state and one-byte decode step of the UTF-8 decoder.
`default_nettype none

`include "assert_macros.svh"

module u8dec_seq (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       go,
	input  wire logic [u8dec_pkg::ByteW-1:0] byte_in,
	input  wire logic                       short_mode,
	output u8dec_pkg::result_t              res
);
	import u8dec_pkg::*;

	logic [LenW-1:0]  bytes_left_q, bytes_left_d;
	logic [LenW-1:0]  total_q, total_d;
	logic [CpW-1:0]   acc_q, acc_d;
	logic [LenW-1:0]  n;
	logic [CpW-1:0]   acc_shift;

	// Lead byte decode and the accumulator shifted by one continuation byte.
	assign n         = lead_length(byte_in, short_mode);
	assign acc_shift = {acc_q[CpW-ContBits-1:0], byte_in[ContBits-1:0]};

	// Next state and result for the byte presented this cycle.
	always_comb begin
		res          = '0;
		res.status   = ST_OK;
		bytes_left_d = bytes_left_q;
		total_d      = total_q;
		acc_d        = acc_q;
		if (go) begin
			if (bytes_left_q == '0) begin
				if (!byte_in[ByteW-1]) begin
					res.valid      = 1'b1;
					res.code_point = {{(CpW-ByteW){1'b0}}, byte_in};
					res.seq_length = 3'd1;
				end else if (n == '0) begin
					res.valid  = 1'b1;
					res.status = ST_BAD_LEAD;
				end else begin
					acc_d        = {{(CpW-ByteW){1'b0}}, lead_payload(byte_in, n)};
					total_d      = n;
					bytes_left_d = n - 3'd1;
				end
			end else if ((byte_in & ContSel) != ContTag) begin
				res.valid    = 1'b1;
				res.status   = ST_BAD_CONT;
				bytes_left_d = '0;
				total_d      = '0;
				acc_d        = '0;
			end else if (bytes_left_q == 3'd1) begin
				res.valid      = 1'b1;
				res.code_point = acc_shift;
				res.seq_length = total_q;
				bytes_left_d   = '0;
				total_d        = '0;
				acc_d          = '0;
			end else begin
				acc_d        = acc_shift;
				bytes_left_d = bytes_left_q - 3'd1;
			end
		end
	end

	// Sequence state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			total_q      <= '0;
			acc_q        <= '0;
		end else begin
			bytes_left_q <= bytes_left_d;
			total_q      <= total_d;
			acc_q        <= acc_d;
		end
	end

	// An open sequence always has more bytes in total than remain.
	`ASSERT_PROP(a_len_order, clk, arst_n, (bytes_left_q != '0) |-> (total_q > bytes_left_q), "remaining bytes exceed sequence length")
	// Between sequences nothing is left in the accumulator.
	`ASSERT_PROP(a_idle_clear, clk, arst_n, (bytes_left_q == '0) |-> (acc_q == '0 && total_q == '0), "stale sequence state while idle")

endmodule

`default_nettype wire
